@@ hw/rtl/mrph_pkg.sv @@
// ----------------------------------------------------------------------------
// mrph_pkg
// Shared types and constants of the mixed-radix pattern histogram: the item
// and result payloads, configuration registers, and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package mrph_pkg;

  // field widths fixed by the item and result formats
  localparam int OPCODE_W    = 1;
  localparam int SID_FIELD_W = 6;
  localparam int FVAL_W      = 5;
  localparam int RPAT_W      = 11;
  localparam int STATUS_W    = 2;
  localparam int PIDX_W      = 11;
  localparam int COUNT_OUT_W = 16;
  localparam int TOTAL_W     = 24;
  localparam int NUM_FEAT_FIELDS = 6;

  // pattern accumulator: 5-bit radices over six digits stay below 31^6 < 2^30
  localparam int PAT_ACC_W = 30;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_RECORD = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SAMPLE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FEATURE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND      = 2'd3;

  // register map, word addressed
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FEATURE_COUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FEATURE_SIZE0 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FEATURE_SIZE1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FEATURE_SIZE2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FEATURE_SIZE3 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FEATURE_SIZE4 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FEATURE_SIZE5 = 3'd7;

  // register reset values
  localparam logic [5:0] RST_SAMPLE_COUNT  = 6'd32;
  localparam logic [2:0] RST_FEATURE_COUNT = 3'd5;
  localparam logic [4:0] RST_FEATURE_SIZE0 = 5'd6;
  localparam logic [4:0] RST_FEATURE_SIZE1 = 5'd4;
  localparam logic [4:0] RST_FEATURE_SIZE2 = 5'd4;
  localparam logic [4:0] RST_FEATURE_SIZE3 = 5'd4;
  localparam logic [4:0] RST_FEATURE_SIZE4 = 5'd4;
  localparam logic [4:0] RST_FEATURE_SIZE5 = 5'd1;

  typedef struct packed {
    logic [OPCODE_W-1:0]    opcode;
    logic [SID_FIELD_W-1:0] sample_id;
    logic [FVAL_W-1:0]      feature_value_0;
    logic [FVAL_W-1:0]      feature_value_1;
    logic [FVAL_W-1:0]      feature_value_2;
    logic [FVAL_W-1:0]      feature_value_3;
    logic [FVAL_W-1:0]      feature_value_4;
    logic [FVAL_W-1:0]      feature_value_5;
    logic [RPAT_W-1:0]      read_pattern;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [PIDX_W-1:0]      pattern_index;
    logic [COUNT_OUT_W-1:0] count;
    logic [TOTAL_W-1:0]     total_recorded;
  } result_t;

  typedef struct packed {
    logic [5:0]                             sample_count;
    logic [2:0]                             feature_count;
    logic [NUM_FEAT_FIELDS-1:0][FVAL_W-1:0] feature_size;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic step;
    logic look;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic feat_stop;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/mrph_ram.sv @@
// ----------------------------------------------------------------------------
// mrph_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mrph_cfg.sv @@
// ----------------------------------------------------------------------------
// mrph_cfg
// Configuration register file behind the APB-style port: sample count,
// feature count and the six feature radices.
// ----------------------------------------------------------------------------
`default_nettype none

module mrph_cfg import mrph_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_count    <= RST_SAMPLE_COUNT;
      cfg.feature_count   <= RST_FEATURE_COUNT;
      cfg.feature_size[0] <= RST_FEATURE_SIZE0;
      cfg.feature_size[1] <= RST_FEATURE_SIZE1;
      cfg.feature_size[2] <= RST_FEATURE_SIZE2;
      cfg.feature_size[3] <= RST_FEATURE_SIZE3;
      cfg.feature_size[4] <= RST_FEATURE_SIZE4;
      cfg.feature_size[5] <= RST_FEATURE_SIZE5;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SAMPLE_COUNT:  cfg.sample_count    <= pwdata[5:0];
        REG_FEATURE_COUNT: cfg.feature_count   <= pwdata[2:0];
        REG_FEATURE_SIZE0: cfg.feature_size[0] <= pwdata[FVAL_W-1:0];
        REG_FEATURE_SIZE1: cfg.feature_size[1] <= pwdata[FVAL_W-1:0];
        REG_FEATURE_SIZE2: cfg.feature_size[2] <= pwdata[FVAL_W-1:0];
        REG_FEATURE_SIZE3: cfg.feature_size[3] <= pwdata[FVAL_W-1:0];
        REG_FEATURE_SIZE4: cfg.feature_size[4] <= pwdata[FVAL_W-1:0];
        REG_FEATURE_SIZE5: cfg.feature_size[5] <= pwdata[FVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_SAMPLE_COUNT:  prdata = PDATA_W'(cfg.sample_count);
      REG_FEATURE_COUNT: prdata = PDATA_W'(cfg.feature_count);
      REG_FEATURE_SIZE0: prdata = PDATA_W'(cfg.feature_size[0]);
      REG_FEATURE_SIZE1: prdata = PDATA_W'(cfg.feature_size[1]);
      REG_FEATURE_SIZE2: prdata = PDATA_W'(cfg.feature_size[2]);
      REG_FEATURE_SIZE3: prdata = PDATA_W'(cfg.feature_size[3]);
      REG_FEATURE_SIZE4: prdata = PDATA_W'(cfg.feature_size[4]);
      REG_FEATURE_SIZE5: prdata = PDATA_W'(cfg.feature_size[5]);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/mrph_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrph_ctrl
// Sequencing state machine: clearing pass after reset, then per transaction
// the digit loop, the counter lookup and the update/result commit.
// ----------------------------------------------------------------------------
`default_nettype none

module mrph_ctrl import mrph_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FEAT  = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FEAT;
        end
      end
      S_FEAT: begin
        if (stat.feat_stop) begin
          state_next = S_LOOK;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mrph_dp.sv @@
// ----------------------------------------------------------------------------
// mrph_dp
// Datapath: item holding register, mixed-radix digit accumulator, counter
// store with saturating update, running total and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrph_dp import mrph_pkg::*; #(
  parameter int MAX_SAMPLES  = 32,
  parameter int MAX_PATTERNS = 2048,
  parameter int MAX_FEATURES = 6,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  item_t    item,
  input  cfg_t     cfg,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result
);

  localparam int SID_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int PAT_W  = $clog2(MAX_PATTERNS);
  localparam int ADDR_W = SID_W + PAT_W;
  localparam int DEPTH  = 1 << ADDR_W;

  item_t                  cur;
  logic [PAT_ACC_W-1:0]   pat;
  logic [PAT_ACC_W-1:0]   digit;
  logic [2:0]             idx;
  logic [ADDR_W-1:0]      clear_addr;
  logic [TOTAL_W-1:0]     total;

  logic                   is_read;
  logic                   sample_bad;
  logic [2:0]             nfeat;
  logic                   feat_done;
  logic                   feat_bad;
  logic                   beyond;
  logic [FVAL_W-1:0]      cur_v;
  logic [FVAL_W-1:0]      cur_size;
  logic [PAT_ACC_W-1:0]   pat_next;
  logic [PAT_ACC_W-1:0]   digit_next;
  logic [STATUS_W-1:0]    status_code;
  logic [SID_W-1:0]       sid_idx;
  logic [ADDR_W-1:0]      look_addr;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [31:0]            cnt_wide;
  logic                   rec_ok;
  logic [TOTAL_W-1:0]     total_next;

  // checks on the held item
  assign is_read    = (cur.opcode == OP_READ);
  assign sample_bad = (cur.sample_id == '0) || (cur.sample_id > cfg.sample_count)
                      || ({3'b000, cur.sample_id} > 9'(MAX_SAMPLES));
  assign nfeat      = (cfg.feature_count > 3'(MAX_FEATURES)) ? 3'(MAX_FEATURES)
                                                             : cfg.feature_count;
  assign feat_done  = (idx >= nfeat);
  assign beyond     = (pat >= PAT_ACC_W'(MAX_PATTERNS));

  // current digit and its radix
  always_comb begin
    case (idx)
      3'd0:    cur_v = cur.feature_value_0;
      3'd1:    cur_v = cur.feature_value_1;
      3'd2:    cur_v = cur.feature_value_2;
      3'd3:    cur_v = cur.feature_value_3;
      3'd4:    cur_v = cur.feature_value_4;
      3'd5:    cur_v = cur.feature_value_5;
      default: cur_v = '0;
    endcase
    case (idx)
      3'd0:    cur_size = cfg.feature_size[0];
      3'd1:    cur_size = cfg.feature_size[1];
      3'd2:    cur_size = cfg.feature_size[2];
      3'd3:    cur_size = cfg.feature_size[3];
      3'd4:    cur_size = cfg.feature_size[4];
      3'd5:    cur_size = cfg.feature_size[5];
      default: cur_size = '0;
    endcase
  end

  assign feat_bad = !feat_done && ((cur_v == '0) || (cur_v > cur_size));

  // one digit of the mixed-radix index per step
  assign pat_next   = pat + PAT_ACC_W'(digit * PAT_ACC_W'(cur_v - 5'd1));
  assign digit_next = PAT_ACC_W'(digit * PAT_ACC_W'(cur_size));

  // result status, sample check first
  always_comb begin
    if (sample_bad) begin
      status_code = STATUS_BAD_SAMPLE;
    end else if (!is_read && feat_bad) begin
      status_code = STATUS_BAD_FEATURE;
    end else if (beyond) begin
      status_code = STATUS_BEYOND;
    end else begin
      status_code = STATUS_OK;
    end
  end

  // status to controller
  assign stat.clear_last = (clear_addr == ADDR_W'(DEPTH - 1));
  assign stat.feat_stop  = sample_bad || is_read || feat_done || feat_bad;
  assign stat.out_free   = !result_valid || result_ready;

  // counter store address and saturating update
  assign sid_idx   = SID_W'(cur.sample_id - 6'd1);
  assign look_addr = {sid_idx, pat[PAT_W-1:0]};
  assign rec_ok    = (status_code == STATUS_OK) && !is_read;
  assign cnt_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
  assign ram_we    = cmd.clear_step || (cmd.commit && rec_ok);
  assign ram_waddr = cmd.clear_step ? clear_addr : look_addr;
  assign ram_wdata = cmd.clear_step ? '0 : cnt_inc;

  mrph_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.look),
    .raddr (look_addr),
    .rdata (ram_rdata)
  );

  // count and total reported with this transaction
  always_comb begin
    if (status_code != STATUS_OK) begin
      cnt_sel = '0;
    end else if (is_read) begin
      cnt_sel = ram_rdata;
    end else begin
      cnt_sel = cnt_inc;
    end
  end

  assign cnt_wide   = 32'(cnt_sel);
  assign total_next = (rec_ok && (total != '1)) ? total + 1'b1 : total;

  // item holding and digit accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur   <= item;
      pat   <= (item.opcode == OP_READ) ? PAT_ACC_W'(item.read_pattern) : '0;
      digit <= PAT_ACC_W'(1);
      idx   <= '0;
    end else if (cmd.step) begin
      pat   <= pat_next;
      digit <= digit_next;
      idx   <= idx + 3'd1;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // running total of accepted records
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.commit) begin
      total <= total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.status         <= status_code;
      result.pattern_index  <= (!is_read && ((status_code == STATUS_BAD_SAMPLE)
                                || (status_code == STATUS_BAD_FEATURE)))
                               ? '0 : pat[PIDX_W-1:0];
      result.count          <= cnt_wide[COUNT_OUT_W-1:0];
      result.total_recorded <= total_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mixed_radix_pattern_histogram_unit.sv @@
// ----------------------------------------------------------------------------
// mixed_radix_pattern_histogram_unit
// Per-sample histogram of mixed-radix mutation patterns with saturating
// counters, a read path for single counters and an APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_ready carry one record or read transaction;
//   result/result_valid/result_ready return exactly one result per item.
//   Registers (sample count, feature count, six radices) sit at 4*i on the
//   APB-style port and should be written only while the unit is idle.
// Timing:
//   an item passes from acceptance through the digit loop, the counter
//   lookup and the commit to its result register; the digit loop folds one
//   feature per cycle through one multiply-add over the F features in use
//   (fewer on an early error). The next item can be accepted once the result
//   is registered, while that result still waits at the output; a new item
//   is not taken before the last one is through.
// Reset:
//   rst loads the register reset values and clears the total, then a clearing
//   pass writes zero to every counter, one per cycle: 2^(SID_W+PAT_W) counters,
//   65536 with the default parameters. item_ready stays low during the pass.
// Back-pressure:
//   a stalled receiver holds the result; the unit finishes the item in hand
//   and then waits before committing the counter update.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_radix_pattern_histogram_unit import mrph_pkg::*; #(
  parameter int MAX_SAMPLES  = 32,
  parameter int MAX_PATTERNS = 2048,
  parameter int MAX_FEATURES = 6,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration registers
  mrph_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencing
  mrph_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath and counter store
  mrph_dp #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_PATTERNS (MAX_PATTERNS),
    .MAX_FEATURES (MAX_FEATURES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
